// ===== hdl/ipid_pkg.sv =====
package ipid_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 16;
  localparam int ERR_W     = 17;
  localparam int ACC_W     = 32 + FRAC_BITS;
  localparam int DRV_W     = 16 + FRAC_BITS;
  localparam int MAC_W     = 64;
  localparam int MUL_CNT_W = 7;
  localparam int DECAY_MUL = 45875;
  localparam int DECAY_SHIFT = 16;

  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_KP     = 3'd1;
  localparam logic [2:0] REG_KI     = 3'd2;
  localparam logic [2:0] REG_KD     = 3'd3;
  localparam logic [2:0] REG_MIN    = 3'd4;
  localparam logic [2:0] REG_MAX    = 3'd5;
  localparam logic [2:0] REG_SCALE  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_MUL_S,
    ST_CLAMP,
    ST_MUL_DECAY,
    ST_DECAY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;

endpackage

// ===== hdl/ipid_serial_mul.sv =====
module ipid_serial_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ipid_pkg::mul_ctl_t           ctl_in,
  input  logic signed [ipid_pkg::ACC_W-1:0] mcand,
  input  logic signed [ipid_pkg::DRV_W-1:0] mplier,
  output logic                         done,
  output logic signed [ipid_pkg::MAC_W-1:0] product
);
  import ipid_pkg::*;

  logic [MUL_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                        run_r, run_nxt;
  logic signed [MAC_W-1:0]     acc_r, acc_nxt;
  logic signed [MAC_W-1:0]     mc_r, mc_nxt;
  logic [DRV_W-1:0]            mp_r, mp_nxt;

  // Shift-add over the multiplier bits, one bit per cycle; the top bit is
  // weighted negatively for two's complement.
  always_comb begin
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    acc_nxt = acc_r;
    mc_nxt  = mc_r;
    mp_nxt  = mp_r;
    done    = ctl_in.busy && !run_r && !ctl_in.start;
    if (ctl_in.start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      acc_nxt = '0;
      mc_nxt  = MAC_W'(mcand);
      mp_nxt  = mplier;
    end else if (run_r) begin
      if (mp_r[0]) begin
        if (cnt_r == MUL_CNT_W'(DRV_W - 1)) acc_nxt = acc_r - mc_r;
        else acc_nxt = acc_r + mc_r;
      end
      mc_nxt = mc_r <<< 1;
      mp_nxt = mp_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(DRV_W - 1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign product = acc_r;

endmodule

// ===== hdl/incremental_pid_pwm_controller_core.sv =====
// A restart or a bad-gain tick goes from acceptance straight to ST_OUT; a
// decay tick passes through ST_MUL_DECAY and ST_DECAY; a control tick makes
// four passes through the shared bit-serial multiplier.
// One beat at a time: the next beat is taken once the result leaves.
// Reset (rst_n, synchronous, active low) clears config, control and PID state.
module incremental_pid_pwm_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic signed [15:0] in_feedback,
  input  logic        in_new_invert,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_drive_level,
  output logic        out_invert_out,
  output logic        out_status,
  output logic        out_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ipid_pkg::*;

  // Configuration registers.
  logic signed [DATA_W-1:0] target_r, kp_r, ki_r, kd_r, min_r, max_r, scale_r;

  // Controller state.
  logic signed [ACC_W-1:0] prev_out_r, prev_out_nxt;
  logic signed [ERR_W-1:0] e1_r, e1_nxt, e2_r, e2_nxt, e_r, e_nxt;
  logic signed [DRV_W-1:0] drive_r, drive_nxt;
  logic                    inv_r, inv_nxt;

  // Working registers for one beat.
  logic signed [MAC_W-1:0] sum_r, sum_nxt;
  logic                    ovf_r, ovf_nxt, stat_r, stat_nxt;
  logic                    oval_r, oval_nxt;
  state_t                  state_r, state_nxt;
  logic                    mstart_r, mstart_nxt;

  mul_ctl_t                  mctl;
  logic signed [ACC_W-1:0]   mcand;
  logic signed [DRV_W-1:0]   mplier;
  logic                      mdone;
  logic signed [MAC_W-1:0]   prod;

  logic signed [ERR_W+1:0]   dp, di, dd;
  logic signed [MAC_W-1:0]   acc_max, acc_min, sat_v, hi_v, lo_v, rnd_v, q_abs;
  logic                      accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE) || oval_r;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0; kp_r <= '0; ki_r <= '0; kd_r <= '0;
      min_r <= '0; max_r <= '0; scale_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET: target_r <= cfg_data;
        REG_KP:     kp_r <= cfg_data;
        REG_KI:     ki_r <= cfg_data;
        REG_KD:     kd_r <= cfg_data;
        REG_MIN:    min_r <= cfg_data;
        REG_MAX:    max_r <= cfg_data;
        REG_SCALE:  scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Error terms feeding the three gain multiplies.
  assign dp = (ERR_W+2)'(e_r) - (ERR_W+2)'(e1_r);
  assign di = (ERR_W+2)'(e_r) + (ERR_W+2)'(e1_r);
  assign dd = (ERR_W+2)'(e_r) - ((ERR_W+2)'(e1_r) <<< 1) + (ERR_W+2)'(e2_r);

  assign acc_max = MAC_W'({1'b0, {(ACC_W-1){1'b1}}});
  assign acc_min = ~acc_max;
  assign sat_v   = (sum_r > acc_max) ? acc_max : ((sum_r < acc_min) ? acc_min : sum_r);
  assign hi_v    = MAC_W'(max_r) <<< FRAC_BITS;
  assign lo_v    = MAC_W'(min_r) <<< FRAC_BITS;
  // Add 1 <<< (2*FRAC_BITS-1), then floor by arithmetic shift of FRAC_BITS.
  assign rnd_v   = (prod + (MAC_W'(1) <<< (2*FRAC_BITS-1))) >>> FRAC_BITS;
  assign q_abs   = (prod < 0) ? -prod : prod;

  // The multiplier is started in the first cycle of each multiply state, so
  // the operands it loads are the ones that state selects.
  assign mstart_nxt = (state_nxt != state_r) &&
                      (state_nxt inside {ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_MUL_S,
                                         ST_MUL_DECAY});

  // Multiplier operand select and start.
  always_comb begin
    mctl.start = mstart_r;
    mctl.busy  = 1'b0;
    mcand  = '0;
    mplier = '0;
    unique case (state_r)
      ST_MUL_P: begin
        mcand = ACC_W'(dp); mplier = DRV_W'(kp_r); mctl.busy = 1'b1;
      end
      ST_MUL_I: begin
        mcand = ACC_W'(di); mplier = DRV_W'(ki_r); mctl.busy = 1'b1;
      end
      ST_MUL_D: begin
        mcand = ACC_W'(dd); mplier = DRV_W'(kd_r); mctl.busy = 1'b1;
      end
      ST_MUL_S: begin
        mcand = prev_out_r; mplier = DRV_W'(scale_r); mctl.busy = 1'b1;
      end
      ST_MUL_DECAY: begin
        mcand = ACC_W'(drive_r); mplier = DRV_W'(DECAY_MUL); mctl.busy = 1'b1;
      end
      default: ;
    endcase
  end

  ipid_serial_mul u_mul (
    .clk(clk), .rst_n(rst_n), .ctl_in(mctl), .mcand(mcand), .mplier(mplier),
    .done(mdone), .product(prod)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op) state_nxt = ST_OUT;
          else if (target_r == '0) state_nxt = ST_MUL_DECAY;
          else if (kp_r <= 0) state_nxt = ST_OUT;
          else state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P:     if (mdone) state_nxt = ST_MUL_I;
      ST_MUL_I:     if (mdone) state_nxt = ST_MUL_D;
      ST_MUL_D:     if (mdone) state_nxt = ST_SUM;
      ST_SUM:       state_nxt = ST_MUL_S;
      ST_MUL_S:     if (mdone) state_nxt = ST_CLAMP;
      ST_CLAMP:     state_nxt = ST_OUT;
      ST_MUL_DECAY: if (mdone) state_nxt = ST_DECAY;
      ST_DECAY:     state_nxt = ST_OUT;
      ST_OUT:       state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    prev_out_nxt = prev_out_r;
    e1_nxt = e1_r; e2_nxt = e2_r; e_nxt = e_r;
    drive_nxt = drive_r; inv_nxt = inv_r;
    sum_nxt = sum_r; ovf_nxt = ovf_r; stat_nxt = stat_r;
    oval_nxt = oval_r;
    if (oval_r && !out_stall) oval_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ovf_nxt = 1'b0;
          stat_nxt = 1'b0;
          e_nxt = ERR_W'(target_r) - ERR_W'(in_feedback);
          sum_nxt = MAC_W'(prev_out_r);
          if (in_op) begin
            prev_out_nxt = '0; e1_nxt = '0; e2_nxt = '0;
            inv_nxt = in_new_invert;
          end else if (target_r != '0 && kp_r <= 0) begin
            stat_nxt = 1'b1;
          end
        end
      end
      ST_MUL_P: if (mdone) sum_nxt = sum_r + prod;
      ST_MUL_I: if (mdone) sum_nxt = sum_r + ((prod + MAC_W'(1)) >>> 1);
      ST_MUL_D: if (mdone) sum_nxt = sum_r + prod;
      ST_SUM: begin
        ovf_nxt = (sat_v != sum_r);
        prev_out_nxt = ACC_W'(sat_v);
        e2_nxt = e1_r;
        e1_nxt = e_r;
      end
      ST_MUL_S: if (mdone) sum_nxt = rnd_v;
      ST_CLAMP: begin
        if (sum_r > hi_v) sum_nxt = hi_v;
        else sum_nxt = sum_r;
        if (sum_nxt < lo_v) sum_nxt = lo_v;
        drive_nxt = DRV_W'(sum_nxt);
      end
      ST_MUL_DECAY: if (mdone) sum_nxt = prod;
      ST_DECAY: begin
        drive_nxt = (sum_r < 0) ? -DRV_W'(q_abs >>> DECAY_SHIFT)
                                :  DRV_W'(sum_r >>> DECAY_SHIFT);
      end
      ST_OUT: oval_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mstart_r <= 1'b0;
      oval_r <= 1'b0;
      prev_out_r <= '0; e1_r <= '0; e2_r <= '0;
      drive_r <= '0; inv_r <= 1'b0;
      ovf_r <= 1'b0; stat_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mstart_r <= mstart_nxt;
      oval_r <= oval_nxt;
      prev_out_r <= prev_out_nxt; e1_r <= e1_nxt; e2_r <= e2_nxt;
      drive_r <= drive_nxt; inv_r <= inv_nxt;
      ovf_r <= ovf_nxt; stat_r <= stat_nxt;
    end
    e_r <= e_nxt;
    sum_r <= sum_nxt;
  end

  assign out_valid       = oval_r;
  assign out_drive_level = drive_r[DRV_W-1:FRAC_BITS];
  assign out_invert_out  = inv_r;
  assign out_status      = stat_r;
  assign out_overflow    = ovf_r;

endmodule

// ===== hdl/ipid_checker.sv =====
module ipid_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_status,
  input logic out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second beat taken while busy");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_status && out_overflow)) else $error("status and overflow");

endmodule

bind incremental_pid_pwm_controller_core ipid_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_overflow(out_overflow)
);
